// File: rtl/bsig_pkg.sv
// Shared constants and codes of the binary split information gain block.
package bsig_pkg;

    // Default set bound and fixed field widths
    localparam int BSIG_MAX_SAMPLES = 1024;
    localparam int NUM_FEATURES     = 16;
    localparam int FEAT_W           = 16;
    localparam int SEL_W            = 4;
    localparam int LABEL_W          = 2;
    localparam int OUT_W            = 17;

    // Log unit: fraction bits of the result and width of the mantissa
    localparam int LG_FRAC_W = 16;
    localparam int MANT_W    = 32;

    // Class bookkeeping
    localparam int NUM_CLASSES     = 3;
    localparam int CLS_W           = 2;
    localparam int TERMS_PER_GROUP = 4;
    localparam int NUM_TERMS       = 12;

    // Label codes of the sample
    localparam logic [LABEL_W-1:0] LBL_ONE = 2'd1;
    localparam logic [LABEL_W-1:0] LBL_TWO = 2'd2;

    // Counter index of each class
    localparam logic [CLS_W-1:0] CLS_ONE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_TWO   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;

endpackage

// File: rtl/bsig_sample_if.sv
// Sample channel: valid, ready and the fields of one training sample.
interface bsig_sample_if import bsig_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               sample_used;
    logic [FEAT_W-1:0]  feature_bits;
    logic [LABEL_W-1:0] class_label;
    logic               last_sample;

    modport source (output valid, output sample_used, output feature_bits,
                    output class_label, output last_sample, input ready);
    modport sink   (input valid, input sample_used, input feature_bits,
                    input class_label, input last_sample, output ready);
endinterface

// File: rtl/bsig_result_if.sv
// Result channel: valid, ready and the fields of one gain result.
interface bsig_result_if import bsig_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] info_gain;
    logic [OUT_W-1:0] parent_entropy;
    logic             empty_set;
    logic             count_overflow;

    modport source (output valid, output info_gain, output parent_entropy,
                    output empty_set, output count_overflow, input ready);
    modport sink   (input valid, input info_gain, input parent_entropy,
                    input empty_set, input count_overflow, output ready);
endinterface

// File: rtl/bsig_counts.sv
// Saturating per-class sample counters for the left and right side of the split.
module bsig_counts import bsig_pkg::*; #(
    parameter int MAX_SAMPLES = BSIG_MAX_SAMPLES,
    parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bump,
    input  logic             i_right,
    input  logic [CLS_W-1:0] i_cls,
    input  logic             i_clear,
    output logic [CW-1:0]    o_left  [NUM_CLASSES],
    output logic [CW-1:0]    o_right [NUM_CLASSES],
    output logic             o_overflow
);

    logic [CW-1:0] r_left  [NUM_CLASSES];
    logic [CW-1:0] r_right [NUM_CLASSES];
    logic          r_overflow;

    // Count one sample on its side, hold at the bound and flag it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_left[i]  <= '0;
                r_right[i] <= '0;
            end
            r_overflow <= 1'b0;
        end else if (i_bump) begin
            if (i_right) begin
                if (r_right[i_cls] >= CW'(MAX_SAMPLES)) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_right[i_cls] <= r_right[i_cls] + 1'b1;
                end
            end else begin
                if (r_left[i_cls] >= CW'(MAX_SAMPLES)) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_left[i_cls] <= r_left[i_cls] + 1'b1;
                end
            end
        end
    end

    assign o_left     = r_left;
    assign o_right    = r_right;
    assign o_overflow = r_overflow;

endmodule

// File: rtl/bsig_log2.sv
// Iterative log2 in Q.16: shift to normalize, then one squaring per fraction bit.
module bsig_log2 import bsig_pkg::*; #(
    parameter int XW = 13,
    parameter int KW = $clog2(XW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [XW-1:0]          i_x,
    output logic                   o_done,
    output logic [KW+LG_FRAC_W-1:0] o_lg
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQR  = 2'd2;

    localparam int CNTW = $clog2(LG_FRAC_W);

    logic [1:0]           r_state;
    logic                 r_done;
    logic [MANT_W-1:0]    r_m;
    logic [KW-1:0]        r_k;
    logic [LG_FRAC_W-1:0] r_frac;
    logic [CNTW-1:0]      r_cnt;
    logic [2*MANT_W-1:0]  sq;

    // Square the mantissa; the top bit decides the next fraction bit
    assign sq = (2*MANT_W)'(r_m) * (2*MANT_W)'(r_m);

    // Sequence: load, shift until the msb sits on top, then square; a zero input is done at load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (i_x == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_m[MANT_W-1]) begin
                        r_state <= L_SQR;
                    end
                end
                L_SQR: begin
                    if (r_cnt == CNTW'(LG_FRAC_W - 1)) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    // Mantissa, exponent and fraction datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_m    <= {i_x, {(MANT_W - XW){1'b0}}};
                    r_k    <= (i_x == '0) ? '0 : KW'(XW - 1);
                    r_frac <= '0;
                    r_cnt  <= '0;
                end
            end
            L_NORM: begin
                if (!r_m[MANT_W-1]) begin
                    r_m <= {r_m[MANT_W-2:0], 1'b0};
                    r_k <= r_k - 1'b1;
                end
            end
            L_SQR: begin
                r_cnt <= r_cnt + 1'b1;
                if (sq[2*MANT_W-1]) begin
                    r_m    <= sq[2*MANT_W-1:MANT_W];
                    r_frac <= {r_frac[LG_FRAC_W-2:0], 1'b1};
                end else begin
                    r_m    <= sq[2*MANT_W-2:MANT_W-1];
                    r_frac <= {r_frac[LG_FRAC_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_lg   = {r_k, r_frac};

endmodule

// File: rtl/bsig_div.sv
// Restoring divider, one quotient bit per cycle.
module bsig_div import bsig_pkg::*; #(
    parameter int DW = 37,
    parameter int VW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_dvs;
    logic [DW-1:0]   r_quo;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            fits;

    // Bring down the next dividend bit and try the subtract
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CNTW'(DW);
        end else if (r_busy) begin
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/binary_split_information_gain.sv
// Binary split information gain: class counting per sample, entropy sequencer per set.
// A sample that is not last leaves the block idle; ready stays high every cycle while idle.
// A last sample holds ready low while the shared log unit works (normalize shifts plus
// one squaring per fraction bit for each term, 12 terms) and the one-bit-per-cycle divider
// runs twice, and while an earlier result still waits in the output register; the result
// shows as ready returns.
// Synchronous active-low reset clears the counters, the select register and the result valid flag.
module binary_split_information_gain import bsig_pkg::*; #(
    parameter int MAX_SAMPLES = BSIG_MAX_SAMPLES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEL_W-1:0] i_cfg_wdata,
    bsig_sample_if.sink      i_sample,
    bsig_result_if.source    o_result
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int NW = $clog2(6 * MAX_SAMPLES + 1);
    localparam int KW = $clog2(NW);
    localparam int LW = LG_FRAC_W + KW;
    localparam int PW = NW + LW;
    localparam int AW = PW + 5;
    localparam int DW = AW - 1;
    localparam int TW = $clog2(NUM_TERMS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TERM  = 4'd2;
    localparam logic [3:0] S_LOG   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DIVP  = 4'd5;
    localparam logic [3:0] S_DIVPW = 4'd6;
    localparam logic [3:0] S_DIVG  = 4'd7;
    localparam logic [3:0] S_DIVGW = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [SEL_W-1:0]        r_feature_select;
    logic [TW-1:0]           r_t;

    logic                    accept;
    logic [CLS_W-1:0]        sample_cls;
    logic                    sample_right;
    logic                    cnt_clear;
    logic [CW-1:0]           cnt_left  [NUM_CLASSES];
    logic [CW-1:0]           cnt_right [NUM_CLASSES];
    logic                    cnt_ovf;

    logic [NW-1:0]           tot_l;
    logic [NW-1:0]           tot_r;
    logic [NW-1:0]           tot_n;
    logic [NW-1:0]           par [NUM_CLASSES];
    logic [NW-1:0]           term_x;
    logic                    term_neg;
    logic                    term_parent;

    logic                    log_start;
    logic                    log_done;
    logic [LW-1:0]           log_lg;

    logic [PW-1:0]           r_prod;
    logic signed [AW-1:0]    prod_ext;
    logic signed [AW-1:0]    r_acc_p;
    logic signed [AW-1:0]    r_acc_c;
    logic signed [AW-1:0]    wp;
    logic signed [AW-1:0]    gval;

    logic                    div_start;
    logic                    div_done;
    logic [DW-1:0]           div_dividend;
    logic [DW-1:0]           div_quo;
    logic [OUT_W-1:0]        quo_cap;

    logic [OUT_W-1:0]        r_pent;
    logic [OUT_W-1:0]        r_gain;
    logic                    r_empty;
    logic                    r_o_valid;
    logic [OUT_W-1:0]        r_o_gain;
    logic [OUT_W-1:0]        r_o_pent;
    logic                    r_o_empty;
    logic                    r_o_ovf;

    // Sample transfer and routing to a class counter
    assign i_sample.ready = (r_state == S_IDLE);
    assign accept         = i_sample.valid && i_sample.ready;

    always_comb begin
        unique case (i_sample.class_label)
            LBL_ONE: sample_cls = CLS_ONE;
            LBL_TWO: sample_cls = CLS_TWO;
            default: sample_cls = CLS_OTHER;
        endcase
    end

    assign sample_right = (32'(r_feature_select) < NUM_FEATURES) &&
                          i_sample.feature_bits[r_feature_select];

    bsig_counts #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW)
    ) u_counts (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bump     (accept && i_sample.sample_used),
        .i_right    (sample_right),
        .i_cls      (sample_cls),
        .i_clear    (cnt_clear),
        .o_left     (cnt_left),
        .o_right    (cnt_right),
        .o_overflow (cnt_ovf)
    );

    // Side and parent totals
    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            par[i] = NW'(cnt_left[i]) + NW'(cnt_right[i]);
        end
        tot_l = NW'(cnt_left[0]) + NW'(cnt_left[1]) + NW'(cnt_left[2]);
        tot_r = NW'(cnt_right[0]) + NW'(cnt_right[1]) + NW'(cnt_right[2]);
        tot_n = tot_l + tot_r;
    end

    // Pick the count of the current term: parent, left, right; total first
    always_comb begin
        case (r_t)
            TW'(0):  term_x = tot_n;
            TW'(1):  term_x = par[0];
            TW'(2):  term_x = par[1];
            TW'(3):  term_x = par[2];
            TW'(4):  term_x = tot_l;
            TW'(5):  term_x = NW'(cnt_left[0]);
            TW'(6):  term_x = NW'(cnt_left[1]);
            TW'(7):  term_x = NW'(cnt_left[2]);
            TW'(8):  term_x = tot_r;
            TW'(9):  term_x = NW'(cnt_right[0]);
            TW'(10): term_x = NW'(cnt_right[1]);
            TW'(11): term_x = NW'(cnt_right[2]);
            default: term_x = '0;
        endcase
    end

    assign term_neg    = (r_t[1:0] != '0);
    assign term_parent = (r_t < TW'(TERMS_PER_GROUP));
    assign prod_ext    = AW'(r_prod);

    bsig_log2 #(
        .XW (NW),
        .KW (KW)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (term_x),
        .o_done  (log_done),
        .o_lg    (log_lg)
    );

    // Clamp the parent sum, form the gain numerator, choose the dividend
    assign wp   = r_acc_p[AW-1] ? '0 : r_acc_p;
    assign gval = wp - r_acc_c;

    assign div_dividend = (r_state == S_DIVG) ?
                          (gval[AW-1] ? '0 : gval[DW-1:0]) : wp[DW-1:0];

    bsig_div #(
        .DW (DW),
        .VW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (tot_n),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    assign quo_cap = (div_quo[DW-1:OUT_W] != '0) ? '1 : div_quo[OUT_W-1:0];

    // Sequencer over the terms and the two divisions
    always_comb begin
        n_state   = r_state;
        log_start = 1'b0;
        div_start = 1'b0;
        cnt_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sample.last_sample) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = (tot_n == '0) ? S_OUT : S_TERM;
            S_TERM: begin
                log_start = 1'b1;
                n_state   = S_LOG;
            end
            S_LOG: begin
                if (log_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: n_state = (r_t == TW'(NUM_TERMS - 1)) ? S_DIVP : S_TERM;
            S_DIVP: begin
                div_start = 1'b1;
                n_state   = S_DIVPW;
            end
            S_DIVPW: begin
                if (div_done) begin
                    n_state = S_DIVG;
                end
            end
            S_DIVG: begin
                div_start = 1'b1;
                n_state   = S_DIVGW;
            end
            S_DIVGW: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_result.ready) begin
                    cnt_clear = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_feature_select <= '0;
            r_t              <= '0;
            r_o_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_feature_select <= i_cfg_wdata;
            end
            if (r_state == S_CHECK) begin
                r_t <= '0;
            end else if (r_state == S_ACC) begin
                r_t <= r_t + 1'b1;
            end
            if (cnt_clear) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Entropy datapath and result hold
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_acc_p <= '0;
            r_acc_c <= '0;
            r_pent  <= '0;
            r_gain  <= '0;
            r_empty <= (tot_n == '0);
        end
        if (r_state == S_LOG && log_done) begin
            r_prod <= PW'(term_x) * PW'(log_lg);
        end
        if (r_state == S_ACC) begin
            if (term_parent) begin
                r_acc_p <= term_neg ? r_acc_p - prod_ext : r_acc_p + prod_ext;
            end else begin
                r_acc_c <= term_neg ? r_acc_c - prod_ext : r_acc_c + prod_ext;
            end
        end
        if (r_state == S_DIVPW && div_done) begin
            r_pent <= quo_cap;
        end
        if (r_state == S_DIVGW && div_done) begin
            r_gain <= quo_cap;
        end
        if (cnt_clear) begin
            r_o_gain  <= r_gain;
            r_o_pent  <= r_pent;
            r_o_empty <= r_empty;
            r_o_ovf   <= cnt_ovf;
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.info_gain      = r_o_gain;
    assign o_result.parent_entropy = r_o_pent;
    assign o_result.empty_set      = r_o_empty;
    assign o_result.count_overflow = r_o_ovf;

endmodule

// File: rtl/bsig_checker.sv
// Port-level checks of the information gain block, bound to the top level.
module bsig_checker import bsig_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_info_gain,
    input logic [OUT_W-1:0] i_parent_entropy,
    input logic             i_empty_set,
    input logic             i_count_overflow
);

    // Hold the result while the sink stalls
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_out_valid && !i_out_ready)) |->
        (i_out_valid && $stable(i_info_gain) && $stable(i_parent_entropy) &&
         $stable(i_empty_set) && $stable(i_count_overflow)))
        else $error("result changed while stalled");

    // An empty set reports zero entropy, zero gain and no saturation
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_empty_set) |->
        (i_info_gain == '0 && i_parent_entropy == '0 && !i_count_overflow))
        else $error("empty set with nonzero result");

    // Gain never exceeds the parent entropy
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_info_gain <= i_parent_entropy))
        else $error("gain above parent entropy");

    // Drop ready after the transfer of a last sample
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("ready held after last sample");

endmodule

bind binary_split_information_gain bsig_checker u_bsig_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_sample.valid),
    .i_in_ready       (i_sample.ready),
    .i_in_last        (i_sample.last_sample),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_info_gain      (o_result.info_gain),
    .i_parent_entropy (o_result.parent_entropy),
    .i_empty_set      (o_result.empty_set),
    .i_count_overflow (o_result.count_overflow)
);
